// ===== hw/rtl/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared widths, types and constants for the plane-from-points datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

  localparam int COORD_W    = 16;
  localparam int EDGE_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int MAG_W      = CROSS_W - 1;
  localparam int POS_W      = 6;
  localparam int NORM_W     = 31;
  localparam int NORM_TOP   = NORM_W - 1;
  localparam int SQ_W       = 2 * NORM_W;
  localparam int SUM_W      = 64;
  localparam int LEN_W      = 32;
  localparam int SQ_BITS    = 32;
  localparam int SQ_PER     = 2;
  localparam int SQ_STAGES  = SQ_BITS / SQ_PER;
  localparam int DIV_BITS   = 15;
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = (DIV_BITS + DIV_PER - 1) / DIV_PER;
  localparam int NUM_W      = 48;
  localparam int DEN_W      = LEN_W + 1;
  localparam int NRM_W      = 16;
  localparam int MUL_W      = NRM_W + COORD_W;
  localparam int ACC_W      = MUL_W + 3;
  localparam int RND_W      = 22;
  localparam int FRAC_DROP  = 14;
  localparam int ROUND_HALF = 8192;
  localparam int OFF_W      = 17;
  localparam int DIST_W     = 18;
  localparam int OFF_MAX    = (1 << (OFF_W - 1)) - 1;
  localparam int OFF_MIN    = -(1 << (OFF_W - 1));
  localparam int DIST_MAX   = (1 << (DIST_W - 1)) - 1;
  localparam int DIST_MIN   = -(1 << (DIST_W - 1));
  localparam int IN_W       = 12 * COORD_W;
  localparam int RES_W      = 3 * NRM_W + OFF_W + DIST_W;
  localparam int OUT_W      = ((RES_W + 7) / 8) * 8;

  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec_t;
  typedef logic [NORM_W-1:0] norm_mag_t;
  typedef logic [DIV_BITS-1:0] quo_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
    vec_t q;
  } pts_t;

  typedef struct packed {
    vec_t       a;
    vec_t       q;
    logic [2:0] neg;
    logic       degen;
  } side_t;

  typedef struct packed {
    logic [2:0][NRM_W-1:0] n;
    logic [OFF_W-1:0]      off;
    logic [DIST_W-1:0]     sdist;
    logic                  degen;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfd_front.sv =====
// ----------------------------------------------------------------------------
// pfd_front
// Edges, cross product, magnitudes and shared normalization to [2^30, 2^31).
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  pfd_pkg::pts_t          in_pts,
  output logic                   out_vld,
  output pfd_pkg::norm_mag_t [2:0] out_m,
  output pfd_pkg::side_t         out_side
);
  import pfd_pkg::*;

  logic [5:0]                vld_r;
  side_t                     sd_r [6];
  logic signed [EDGE_W-1:0]  e1_r [3];
  logic signed [EDGE_W-1:0]  e2_r [3];
  logic signed [PROD_W-1:0]  prod_r [6];
  logic signed [CROSS_W-1:0] cr_r [3];
  logic [MAG_W-1:0]          mag_r [3];
  logic [MAG_W-1:0]          or_r;
  logic [MAG_W-1:0]          mag5_r [3];
  logic [POS_W-1:0]          pos_r;
  logic [POS_W-1:0]          pos_nxt;
  norm_mag_t                 m_r [3];
  norm_mag_t                 m_nxt [3];
  side_t                     sd0_nxt;
  side_t                     sd3_nxt;

  always_comb begin
    sd0_nxt       = '0;
    sd0_nxt.a     = in_pts.a;
    sd0_nxt.q     = in_pts.q;
    sd3_nxt       = sd_r[2];
    sd3_nxt.degen = 1'b1;
    for (int i = 0; i < 3; i++) begin
      sd3_nxt.neg[i] = cr_r[i][CROSS_W-1];
      if (cr_r[i] != '0) sd3_nxt.degen = 1'b0;
    end
  end

  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (or_r[i]) pos_nxt = POS_W'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_r > POS_W'(NORM_TOP)) begin
        m_nxt[i] = NORM_W'(mag5_r[i] >> (pos_r - POS_W'(NORM_TOP)));
      end else begin
        m_nxt[i] = NORM_W'(mag5_r[i] << (POS_W'(NORM_TOP) - pos_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= sd0_nxt;
      sd_r[1] <= sd_r[0];
      sd_r[2] <= sd_r[1];
      sd_r[3] <= sd3_nxt;
      sd_r[4] <= sd_r[3];
      sd_r[5] <= sd_r[4];
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= {in_pts.a[i][COORD_W-1], in_pts.a[i]}
                 - {in_pts.b[i][COORD_W-1], in_pts.b[i]};
        e2_r[i] <= {in_pts.a[i][COORD_W-1], in_pts.a[i]}
                 - {in_pts.c[i][COORD_W-1], in_pts.c[i]};
      end
      prod_r[0] <= e1_r[1] * e2_r[2];
      prod_r[1] <= e2_r[1] * e1_r[2];
      prod_r[2] <= e2_r[0] * e1_r[2];
      prod_r[3] <= e1_r[0] * e2_r[2];
      prod_r[4] <= e1_r[0] * e2_r[1];
      prod_r[5] <= e2_r[0] * e1_r[1];
      cr_r[0]   <= CROSS_W'(prod_r[0]) - CROSS_W'(prod_r[1]);
      cr_r[1]   <= CROSS_W'(prod_r[2]) - CROSS_W'(prod_r[3]);
      cr_r[2]   <= CROSS_W'(prod_r[4]) - CROSS_W'(prod_r[5]);
      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= cr_r[i][CROSS_W-1] ? MAG_W'(-cr_r[i]) : MAG_W'(cr_r[i]);
        mag5_r[i] <= mag_r[i];
        m_r[i]    <= m_nxt[i];
      end
      or_r  <= (cr_r[0][CROSS_W-1] ? MAG_W'(-cr_r[0]) : MAG_W'(cr_r[0]))
             | (cr_r[1][CROSS_W-1] ? MAG_W'(-cr_r[1]) : MAG_W'(cr_r[1]))
             | (cr_r[2][CROSS_W-1] ? MAG_W'(-cr_r[2]) : MAG_W'(cr_r[2]));
      pos_r <= pos_nxt;
    end
  end

  assign out_vld  = vld_r[5];
  assign out_side = sd_r[5];
  always_comb begin
    for (int i = 0; i < 3; i++) out_m[i] = m_r[i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfd_len.sv =====
// ----------------------------------------------------------------------------
// pfd_len
// Sum of squares and a pipelined integer square root, two result bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_len (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  pfd_pkg::norm_mag_t [2:0] in_m,
  input  pfd_pkg::side_t           in_side,
  output logic                     out_vld,
  output logic [pfd_pkg::LEN_W-1:0] out_len,
  output pfd_pkg::norm_mag_t [2:0] out_m,
  output pfd_pkg::side_t           out_side
);
  import pfd_pkg::*;

  logic [SQ_STAGES+1:0]   vld_r;
  logic [SQ_W-1:0]        sq_r [3];
  logic [2:0][NORM_W-1:0] m0_r;
  logic [2:0][NORM_W-1:0] m1_r;
  side_t                  sd0_r;
  side_t                  sd1_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       x_r [SQ_STAGES];
  logic [SUM_W-1:0]       r_r [SQ_STAGES];
  logic [SUM_W-1:0]       x_nxt [SQ_STAGES];
  logic [SUM_W-1:0]       r_nxt [SQ_STAGES];
  logic [SUM_W-1:0]       xin [SQ_STAGES];
  logic [SUM_W-1:0]       rin [SQ_STAGES];
  logic [2:0][NORM_W-1:0] m_r [SQ_STAGES];
  side_t                  sd_r [SQ_STAGES];

  always_comb begin
    logic [SUM_W-1:0] xv;
    logic [SUM_W-1:0] rv;
    logic [SUM_W-1:0] bv;
    logic [SUM_W-1:0] tv;
    xin[0] = sum_r;
    rin[0] = '0;
    for (int s = 1; s < SQ_STAGES; s++) begin
      xin[s] = x_r[s-1];
      rin[s] = r_r[s-1];
    end
    for (int s = 0; s < SQ_STAGES; s++) begin
      xv = xin[s];
      rv = rin[s];
      for (int j = 0; j < SQ_PER; j++) begin
        bv = SUM_W'(1) << (SUM_W - 2 - 2 * (s * SQ_PER + j));
        tv = rv + bv;
        if (xv >= tv) begin
          xv = xv - tv;
          rv = (rv >> 1) + bv;
        end else begin
          rv = rv >> 1;
        end
      end
      x_nxt[s] = xv;
      r_nxt[s] = rv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SQ_STAGES:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= in_m[i] * in_m[i];
      m0_r  <= in_m;
      sd0_r <= in_side;
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      m1_r  <= m0_r;
      sd1_r <= sd0_r;
      m_r[0]  <= m1_r;
      sd_r[0] <= sd1_r;
      for (int s = 1; s < SQ_STAGES; s++) begin
        m_r[s]  <= m_r[s-1];
        sd_r[s] <= sd_r[s-1];
      end
      for (int s = 0; s < SQ_STAGES; s++) begin
        x_r[s] <= x_nxt[s];
        r_r[s] <= r_nxt[s];
      end
    end
  end

  assign out_vld  = vld_r[SQ_STAGES+1];
  assign out_len  = LEN_W'(r_r[SQ_STAGES-1]);
  assign out_m    = m_r[SQ_STAGES-1];
  assign out_side = sd_r[SQ_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/pfd_div.sv =====
// ----------------------------------------------------------------------------
// pfd_div
// Three-lane pipelined restoring divider: round(m * 2^14 / len).
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic [pfd_pkg::LEN_W-1:0] in_len,
  input  pfd_pkg::norm_mag_t [2:0]  in_m,
  input  pfd_pkg::side_t            in_side,
  output logic                      out_vld,
  output pfd_pkg::quo_t [2:0]       out_q,
  output pfd_pkg::side_t            out_side
);
  import pfd_pkg::*;

  logic [DIV_STAGES:0]     vld_r;
  logic [2:0][NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]        den_r;
  side_t                   sd0_r;
  logic [2:0][NUM_W-1:0]   rem_r [DIV_STAGES];
  logic [2:0][NUM_W-1:0]   rem_nxt [DIV_STAGES];
  quo_t [2:0]              q_r [DIV_STAGES];
  quo_t [2:0]              q_nxt [DIV_STAGES];
  logic [DEN_W-1:0]        d_r [DIV_STAGES];
  side_t                   sd_r [DIV_STAGES];
  logic [2:0][NUM_W-1:0]   rin [DIV_STAGES];
  quo_t [2:0]              qin [DIV_STAGES];
  logic [DEN_W-1:0]        din [DIV_STAGES];

  always_comb begin
    logic [NUM_W-1:0] rv;
    logic [NUM_W-1:0] sh;
    quo_t             qv;
    rin[0] = num_r;
    qin[0] = '0;
    din[0] = den_r;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rin[s] = rem_r[s-1];
      qin[s] = q_r[s-1];
      din[s] = d_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int i = 0; i < 3; i++) begin
        rv = rin[s][i];
        qv = qin[s][i];
        for (int j = 0; j < DIV_PER; j++) begin
          if (s * DIV_PER + j < DIV_BITS) begin
            sh = NUM_W'(din[s]) << (DIV_BITS - 1 - (s * DIV_PER + j));
            if (rv >= sh) begin
              rv = rv - sh;
              qv[DIV_BITS - 1 - (s * DIV_PER + j)] = 1'b1;
            end
          end
        end
        rem_nxt[s][i] = rv;
        q_nxt[s][i]   = qv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_STAGES-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUM_W'(in_m[i]) << DIV_BITS) + NUM_W'(in_len);
      end
      den_r <= {in_len, 1'b0};
      sd0_r <= in_side;
      sd_r[0] <= sd0_r;
      d_r[0]  <= den_r;
      for (int s = 1; s < DIV_STAGES; s++) begin
        sd_r[s] <= sd_r[s-1];
        d_r[s]  <= d_r[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES];
  assign out_q    = q_r[DIV_STAGES-1];
  assign out_side = sd_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/pfd_dot.sv =====
// ----------------------------------------------------------------------------
// pfd_dot
// Signed normal, dot products with corner a and query, rounding, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_dot (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  pfd_pkg::quo_t [2:0] in_q,
  input  pfd_pkg::side_t      in_side,
  output logic                out_vld,
  output pfd_pkg::res_t       out_res
);
  import pfd_pkg::*;

  logic [4:0]                vld_r;
  logic signed [NRM_W-1:0]   n1_r [3];
  logic signed [NRM_W-1:0]   n2_r [3];
  logic signed [NRM_W-1:0]   n3_r [3];
  logic signed [NRM_W-1:0]   n4_r [3];
  logic signed [COORD_W-1:0] a1_r [3];
  logic signed [COORD_W-1:0] q1_r [3];
  logic [3:0]                dg_r;
  logic signed [MUL_W-1:0]   pa_r [3];
  logic signed [MUL_W-1:0]   pq_r [3];
  logic signed [ACC_W-1:0]   off_r;
  logic signed [ACC_W-1:0]   dist_r;
  logic signed [RND_W-1:0]   offr_r;
  logic signed [RND_W-1:0]   distr_r;
  res_t                      res_r;
  res_t                      res_nxt;

  function automatic logic signed [RND_W-1:0] rnd_q8(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] rm;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    rm  = (mag + ACC_W'(ROUND_HALF)) >> FRAC_DROP;
    return v[ACC_W-1] ? -RND_W'(rm) : RND_W'(rm);
  endfunction

  always_comb begin
    res_nxt.degen = dg_r[3];
    for (int i = 0; i < 3; i++) res_nxt.n[i] = n4_r[i];
    if (offr_r > OFF_MAX) begin
      res_nxt.off = OFF_W'(OFF_MAX);
    end else if (offr_r < OFF_MIN) begin
      res_nxt.off = OFF_W'(OFF_MIN);
    end else begin
      res_nxt.off = OFF_W'(offr_r);
    end
    if (distr_r > DIST_MAX) begin
      res_nxt.sdist = DIST_W'(DIST_MAX);
    end else if (distr_r < DIST_MIN) begin
      res_nxt.sdist = DIST_W'(DIST_MIN);
    end else begin
      res_nxt.sdist = DIST_W'(distr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dg_r <= {dg_r[2:0], in_side.degen};
      for (int i = 0; i < 3; i++) begin
        if (in_side.degen) begin
          n1_r[i] <= '0;
        end else if (in_side.neg[i]) begin
          n1_r[i] <= -NRM_W'(in_q[i]);
        end else begin
          n1_r[i] <= NRM_W'(in_q[i]);
        end
        a1_r[i] <= in_side.a[i];
        q1_r[i] <= in_side.q[i];
        n2_r[i] <= n1_r[i];
        n3_r[i] <= n2_r[i];
        n4_r[i] <= n3_r[i];
        pa_r[i] <= n1_r[i] * a1_r[i];
        pq_r[i] <= n1_r[i] * q1_r[i];
      end
      off_r   <= -(ACC_W'(pa_r[0]) + ACC_W'(pa_r[1]) + ACC_W'(pa_r[2]));
      dist_r  <= ACC_W'(pq_r[0]) + ACC_W'(pq_r[1]) + ACC_W'(pq_r[2])
               - ACC_W'(pa_r[0]) - ACC_W'(pa_r[1]) - ACC_W'(pa_r[2]);
      offr_r  <= rnd_q8(off_r);
      distr_r <= rnd_q8(dist_r);
      res_r   <= res_nxt;
    end
  end

  assign out_vld = vld_r[4];
  assign out_res = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/plane_from_points_distance.sv =====
// ----------------------------------------------------------------------------
// plane_from_points_distance
// Unit plane normal from three corners, plane offset and query distance.
//
//   port group | dir | payload (low bit first)
//   in_*       | in  | tdata: corner_a_x/y/z, corner_b_x/y/z, corner_c_x/y/z,
//              |     |        query_x/y/z (16 bits each)
//   out_*      | out | tdata: normal_x/y/z (16), plane_offset (17),
//              |     |        signed_distance (18), zero pad; tuser: degenerate
//
// One beat per cycle in and out unless the output stalls. Beats pass the front,
// square-root pipeline (two root bits per stage), three-lane divider and dot.
// All stages advance together whenever the output register is empty or taken.
// Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_from_points_distance (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [pfd_pkg::IN_W-1:0]  in_tdata,   // a xyz, b xyz, c xyz, query xyz
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [pfd_pkg::OUT_W-1:0] out_tdata,  // normal xyz, offset, distance, pad
  output logic                      out_tuser   // degenerate
);
  import pfd_pkg::*;

  logic               adv;
  pts_t               pts;
  logic               f_vld;
  norm_mag_t [2:0]    f_m;
  side_t              f_side;
  logic               l_vld;
  logic [LEN_W-1:0]   l_len;
  norm_mag_t [2:0]    l_m;
  side_t              l_side;
  logic               d_vld;
  quo_t [2:0]         d_q;
  side_t              d_side;
  res_t               res;

  assign adv       = out_tready | ~out_tvalid;
  assign in_tready = adv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pts.a[i] = in_tdata[COORD_W*i +: COORD_W];
      pts.b[i] = in_tdata[COORD_W*(3+i) +: COORD_W];
      pts.c[i] = in_tdata[COORD_W*(6+i) +: COORD_W];
      pts.q[i] = in_tdata[COORD_W*(9+i) +: COORD_W];
    end
  end

  pfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_tvalid),
    .in_pts   (pts),
    .out_vld  (f_vld),
    .out_m    (f_m),
    .out_side (f_side)
  );

  pfd_len u_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (f_vld),
    .in_m     (f_m),
    .in_side  (f_side),
    .out_vld  (l_vld),
    .out_len  (l_len),
    .out_m    (l_m),
    .out_side (l_side)
  );

  pfd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (l_vld),
    .in_len   (l_len),
    .in_m     (l_m),
    .in_side  (l_side),
    .out_vld  (d_vld),
    .out_q    (d_q),
    .out_side (d_side)
  );

  pfd_dot u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (d_vld),
    .in_q    (d_q),
    .in_side (d_side),
    .out_vld (out_tvalid),
    .out_res (res)
  );

  assign out_tdata = {(OUT_W - RES_W)'(0), res.sdist, res.off, res.n[2], res.n[1], res.n[0]};
  assign out_tuser = res.degen;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[RES_W-1:0] == '0)
    else $error("degenerate result carries nonzero fields");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      $signed(out_tdata[15:0]) <= 16'sd16384 && $signed(out_tdata[15:0]) >= -16'sd16384 &&
      $signed(out_tdata[31:16]) <= 16'sd16384 && $signed(out_tdata[31:16]) >= -16'sd16384 &&
      $signed(out_tdata[47:32]) <= 16'sd16384 && $signed(out_tdata[47:32]) >= -16'sd16384)
    else $error("normal component out of unit range");
`endif

endmodule

`default_nettype wire

// ===== tb/plane_from_points_distance_test.sv =====
// ----------------------------------------------------------------------------
// plane_from_points_distance_test
// Streams triangles with query points through the plane/distance pipeline.
// A directed table covers extremes, degenerate and axis-aligned planes. A
// random stream follows, mixing full-range, small, collinear and extreme
// coordinates. Every output beat is checked against a table entry or a local
// plane model under bursty input and a patterned, sometimes long, output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_from_points_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pfd_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] sdist;
    logic [OFF_W-1:0]  off;
    logic [15:0]       nz;
    logic [15:0]       ny;
    logic [15:0]       nx;
    logic              degen;
  } plane_t;

  typedef struct {
    logic [IN_W-1:0] pts;
    bit              typed;
    plane_t          want;
  } row_t;

  localparam int RANDOM_ITEMS = 1625;
  localparam int IDLE_LIMIT   = 5000;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  plane_t plane_q[$];
  bit     beat_typed;
  plane_t beat_want;
  int     mismatches;
  int     burst_left;
  int     idle_cycles;
  row_t   rows[$];

  plane_from_points_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint round_q8(longint v);
    longint mg;
    mg = v < 0 ? -v : v;
    mg = (mg + ROUND_HALF) >>> FRAC_DROP;
    return v < 0 ? -mg : mg;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic plane_t predict_plane(logic [IN_W-1:0] d);
    longint p[12];
    longint e1[3];
    longint e2[3];
    longint cr[3];
    longint nv[3];
    longint unsigned m[3];
    longint unsigned mx, acc, len, bitv;
    longint da, dq;
    plane_t r;
    for (int i = 0; i < 12; i++) p[i] = longint'($signed(d[i*COORD_W +: COORD_W]));
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[i] - p[3+i];
      e2[i] = p[i] - p[6+i];
    end
    cr[0] = e1[1] * e2[2] - e2[1] * e1[2];
    cr[1] = e2[0] * e1[2] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e2[0] * e1[1];
    r = '0;
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) m[i] = cr[i] < 0 ? longint'(-cr[i]) : longint'(cr[i]);
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    while (mx >= 64'd1 << 31) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < 64'd1 << 30) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    acc = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = 0;
    bitv = 64'd1 << 62;
    while (bitv > acc) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (acc >= len + bitv) begin
        acc = acc - (len + bitv);
        len = (len >> 1) + bitv;
      end else begin
        len = len >> 1;
      end
      bitv = bitv >> 2;
    end
    da = 0;
    dq = 0;
    for (int i = 0; i < 3; i++) begin
      nv[i] = longint'(((m[i] << 15) + len) / (len << 1));
      if (cr[i] < 0) nv[i] = -nv[i];
      da += nv[i] * p[i];
      dq += nv[i] * p[9+i];
    end
    r.nx    = 16'(nv[0]);
    r.ny    = 16'(nv[1]);
    r.nz    = 16'(nv[2]);
    r.off   = OFF_W'(clamp(round_q8(-da), OFF_MIN, OFF_MAX));
    r.sdist = DIST_W'(clamp(round_q8(dq - da), DIST_MIN, DIST_MAX));
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pts_of(int ax, int ay, int az, int bx, int by, int bz,
                                             int cx, int cy, int cz, int qx, int qy, int qz);
    return {16'(qz), 16'(qy), 16'(qx), 16'(cz), 16'(cy), 16'(cx),
            16'(bz), 16'(by), 16'(bx), 16'(az), 16'(ay), 16'(ax)};
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic logic [IN_W-1:0] random_pts();
    logic [IN_W-1:0] v;
    int a[3];
    int dv[3];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < IN_W / 32; i++) v[i*32 +: 32] = $urandom;
    if (kind == 5 || kind == 6) begin
      for (int i = 0; i < 12; i++) v[i*16 +: 16] = 16'(small_coord());
    end else if (kind == 7) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = small_coord();
        dv[i] = int'($urandom_range(0, 200)) - 100;
        v[i*16 +: 16]     = 16'(a[i]);
        v[(3+i)*16 +: 16] = 16'(a[i] + dv[i]);
        v[(6+i)*16 +: 16] = 16'(a[i] - 2 * dv[i]);
      end
    end else if (kind == 8) begin
      v[3*16 +: 48] = v[0 +: 48];
    end else if (kind == 9) begin
      for (int i = 0; i < 12; i++) v[i*16 +: 16] = 16'(edge_coord());
    end
    return v;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_beat(logic [IN_W-1:0] pts, bit typed, plane_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_tvalid  = 1'b1;
    in_tdata   = pts;
    beat_typed = typed;
    beat_want  = want;
    do @(posedge clk); while (!in_tready);
  endtask

  always @(posedge clk) begin
    plane_t got;
    plane_t want;
    if (rst_n && in_tvalid && in_tready)
      plane_q.push_back(beat_typed ? beat_want : predict_plane(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[RES_W-1:0], out_tuser};
      if (plane_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = plane_q.pop_front();
        if (got.nx != want.nx)
          report_mismatch("normal_x", $signed(got.nx), $signed(want.nx));
        if (got.ny != want.ny)
          report_mismatch("normal_y", $signed(got.ny), $signed(want.ny));
        if (got.nz != want.nz)
          report_mismatch("normal_z", $signed(got.nz), $signed(want.nz));
        if (got.off != want.off)
          report_mismatch("plane_offset", $signed(got.off), $signed(want.off));
        if (got.sdist != want.sdist)
          report_mismatch("signed_distance", $signed(got.sdist), $signed(want.sdist));
        if (got.degen != want.degen)
          report_mismatch("degenerate", got.degen, want.degen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int cyc;
    int mode;
    out_tready = 1'b0;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 1000) begin
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = $urandom_range(0, 9) < 7;
        default: out_tready = $urandom_range(0, 9) < 3;
      endcase
    end
  end

  initial begin
    plane_t none;
    plane_t flat;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    beat_typed = 1'b0;
    beat_want = '0;
    mismatches = 0;
    burst_left = 0;
    idle_cycles = 0;
    none = '0;
    none.degen = 1'b1;
    flat = '0;
    flat.nz = 16'd16384;
    flat.sdist = DIST_W'(256);

    rows.push_back('{pts_of(0,0,0, 0,0,0, 0,0,0, 0,0,0), 1, none});
    rows.push_back('{pts_of(-32768,-32768,-32768, -32768,-32768,-32768,
                            -32768,-32768,-32768, -32768,-32768,-32768), 1, none});
    rows.push_back('{pts_of(32767,32767,32767, 32767,32767,32767,
                            32767,32767,32767, 32767,32767,32767), 1, none});
    rows.push_back('{pts_of(0,0,0, -256,0,0, 0,-256,0, 0,0,256), 1, flat});
    rows.push_back('{pts_of(0,0,0, 256,0,0, 512,0,0, 7,8,9), 1, none});
    rows.push_back('{pts_of(0,0,0, 256,0,0, 0,256,0, 0,0,256), 0, none});
    rows.push_back('{pts_of(0,0,0, 0,256,0, 0,0,256, 256,0,0), 0, none});
    rows.push_back('{pts_of(0,0,0, 0,0,256, 256,0,0, 0,256,0), 0, none});
    rows.push_back('{pts_of(32767,32767,32767, -32768,32767,32767, 32767,-32768,32767,
                            -32768,-32768,-32768), 0, none});
    rows.push_back('{pts_of(-32768,-32768,-32768, 32767,-32768,-32768, -32768,32767,-32768,
                            32767,32767,32767), 0, none});
    rows.push_back('{pts_of(32767,-32768,32767, -32768,32767,-32768, 32767,32767,-32768,
                            -32768,32767,32767), 0, none});
    rows.push_back('{pts_of(-32768,32767,-32768, 32767,-32768,32767, -32768,-32768,32767,
                            32767,-32768,-32768), 0, none});
    rows.push_back('{pts_of(32767,0,0, 0,32767,0, 0,0,32767, -32768,-32768,-32768), 0, none});
    rows.push_back('{pts_of(-32768,0,0, 0,-32768,0, 0,0,-32768, 32767,32767,32767), 0, none});
    rows.push_back('{pts_of(1,0,0, 0,1,0, 0,0,1, 0,0,0), 0, none});
    rows.push_back('{pts_of(0,0,0, 1,0,0, 0,1,0, 32767,-32768,32767), 0, none});
    rows.push_back('{pts_of(100,200,300, 101,200,300, 100,201,300, 100,200,-32768), 0, none});
    rows.push_back('{pts_of(-1,-1,-1, 1,1,1, 1,-1,1, -1,1,-1), 0, none});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_beat(rows[i].pts, rows[i].typed, rows[i].want);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 800) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        while (plane_q.size() != 0) @(negedge clk);
      end
      send_beat(random_pts(), 1'b0, none);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    while (plane_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
